// ----- rtl/ptsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_pkg
// Shared types, constants and helpers of the path tracking steer controller.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  localparam int unsigned MaxPathPointsDef = 1024;
  localparam int unsigned CordicStagesDef  = 16;

  localparam int unsigned AtanIdxW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulW     = 34;
  localparam int unsigned ProdW    = 68;
  localparam int unsigned CordW    = 36;
  localparam int unsigned AngZW    = 34;

  localparam logic [MulW-1:0]  RadToBam      = 34'd683565276;
  localparam logic [CordW-1:0] CordicGainInv = 36'd652032874;

  localparam logic [10:0] PathLengthRst = 11'd2;
  localparam logic [15:0] GainCrossRst  = 16'd256;
  localparam logic [15:0] GainHeadRst   = 16'd256;
  localparam logic [15:0] SpeedRst      = 16'd768;
  localparam logic [15:0] TimeStepRst   = 16'd1638;
  localparam logic [15:0] InvWheelRst   = 16'd64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATH_LENGTH = 3'd0,
    CFG_GAIN_CROSS  = 3'd1,
    CFG_GAIN_HEAD   = 3'd2,
    CFG_SPEED       = 3'd3,
    CFG_TIME_STEP   = 3'd4,
    CFG_INV_WHEEL   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CORDIC_VECTOR = 1'b0,
    CORDIC_ROTATE = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
    logic [32:0]  vec_y;
    logic [32:0]  vec_x;
    logic [15:0]  angle;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] angle;
    logic [31:0] cos_v;
    logic [31:0] sin_v;
  } cordic_rsp_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_entry(input logic [AtanIdxW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ptsc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc channel interfaces
// Command word channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  point_index;
  logic [31:0] point_x;
  logic [31:0] point_y;

  modport source (output valid, operation, point_index, point_x, point_y, input ready);
  modport sink   (input valid, operation, point_index, point_x, point_y, output ready);
endinterface

interface ptsc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] steer_angle;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic [15:0] pose_heading;
  logic [9:0]  nearest_index;
  logic [31:0] cross_track;

  modport source (output valid, steer_angle, pose_x, pose_y, pose_heading,
                  nearest_index, cross_track, input ready);
  modport sink   (input valid, steer_angle, pose_x, pose_y, pose_heading,
                  nearest_index, cross_track, output ready);
endinterface

// ----- rtl/ptsc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module ptsc_mul (
  input  logic                                 clk_i,
  input  logic signed [ptsc_pkg::MulW-1:0]     a_i,
  input  logic signed [ptsc_pkg::MulW-1:0]     b_i,
  output logic        [ptsc_pkg::ProdW-1:0]    prod_o
);

  logic signed [ptsc_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/ptsc_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module ptsc_cordic #(
  parameter int unsigned CORDIC_STAGES = ptsc_pkg::CordicStagesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptsc_pkg::cordic_req_t req_i,
  output ptsc_pkg::cordic_rsp_t rsp_o
);

  localparam logic [ptsc_pkg::AtanIdxW-1:0] LastIter =
    ptsc_pkg::AtanIdxW'(CORDIC_STAGES - 1);

  logic                                   busy_q, done_q, flip_q, zero_q;
  logic [ptsc_pkg::AtanIdxW-1:0]          cnt_q;
  ptsc_pkg::cordic_mode_e                 mode_q;
  logic signed [ptsc_pkg::CordW-1:0]      x_q, y_q, x_d, y_d;
  logic signed [ptsc_pkg::AngZW-1:0]      z_q, z_d;

  logic signed [ptsc_pkg::CordW-1:0]      xs, ys, vx0, vy0;
  logic signed [ptsc_pkg::AngZW-1:0]      tab;
  logic                                   go_neg, rot_flip;
  logic [31:0]                            z32, z_rnd;

  assign rot_flip = req_i.angle[15] ^ req_i.angle[14];
  assign z32      = {req_i.angle[15] ^ rot_flip, req_i.angle[14:0], 16'd0};
  assign vx0      = $signed({{3{req_i.vec_x[32]}}, req_i.vec_x});
  assign vy0      = $signed({{3{req_i.vec_y[32]}}, req_i.vec_y});

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign tab = $signed({2'b00, ptsc_pkg::atan_entry(cnt_q)});
  assign go_neg = (mode_q == ptsc_pkg::CORDIC_VECTOR) ? (y_q > 36'sd0) : z_q[ptsc_pkg::AngZW-1];

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (req_i.start) begin
      if (req_i.mode == ptsc_pkg::CORDIC_VECTOR) begin
        // left half plane: turn by pi first
        if (req_i.vec_x[32]) begin
          x_d = -vx0;
          y_d = -vy0;
          z_d = $signed({2'b00, 32'h8000_0000});
        end else begin
          x_d = vx0;
          y_d = vy0;
          z_d = '0;
        end
      end else begin
        x_d = $signed(ptsc_pkg::CordicGainInv);
        y_d = '0;
        z_d = $signed({{2{z32[31]}}, z32});
      end
    end else if (busy_q) begin
      if (go_neg) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + tab;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - tab;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ptsc_pkg::CORDIC_VECTOR;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        mode_q <= req_i.mode;
        flip_q <= (req_i.mode == ptsc_pkg::CORDIC_ROTATE) && rot_flip;
        zero_q <= (req_i.mode == ptsc_pkg::CORDIC_VECTOR) &&
                  (req_i.vec_x == 33'd0) && (req_i.vec_y == 33'd0);
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_rnd = z_q[31:0] + 32'h0000_8000;

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = zero_q ? 16'd0 : z_rnd[31:16];
  assign rsp_o.cos_v = flip_q ? (32'd0 - x_q[31:0]) : x_q[31:0];
  assign rsp_o.sin_v = flip_q ? (32'd0 - y_q[31:0]) : y_q[31:0];

endmodule

// ----- rtl/path_tracking_steer_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_tracking_steer_controller
// Path following steering controller: nearest point scan, cross track and
// heading error, steer law and kinematic pose advance on shared units.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_i    in   valid/ready          operation, point_index, point_x, point_y
//  rsp_o    out  valid/ready          steer, pose, nearest_index, cross_track
//  cfg      in   cfg_we_i write only  cfg_idx_i, cfg_data_i
//
//  a step scans all n path points; the scan costs two passes through the
//  shared multiplier per point.
//  one word at a time; a finished result waits in the output register while
//  the next word is taken. reset clears pose, configuration and control
//  state; the path table has no clearing pass.
// ----------------------------------------------------------------------------
module path_tracking_steer_controller #(
  parameter int unsigned MAX_PATH_POINTS = ptsc_pkg::MaxPathPointsDef,
  parameter int unsigned CORDIC_STAGES   = ptsc_pkg::CordicStagesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptsc_in_if.sink                        req_i,
  ptsc_out_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [ptsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ptsc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_PATH_POINTS > 1) ? $clog2(MAX_PATH_POINTS) : 1;
  localparam int unsigned NW = ($clog2(MAX_PATH_POINTS + 1) > 11) ?
                               $clog2(MAX_PATH_POINTS + 1) : 11;
  localparam int unsigned MW = ptsc_pkg::MulW;

  typedef enum logic [35:0] {
    ST_IDLE  = 36'd1 << 0,
    ST_S_RD0 = 36'd1 << 1,
    ST_S_RD1 = 36'd1 << 2,
    ST_S_VEC = 36'd1 << 3,
    ST_S_WT  = 36'd1 << 4,
    ST_INIT  = 36'd1 << 5,
    ST_SCAN0 = 36'd1 << 6,
    ST_SCAN1 = 36'd1 << 7,
    ST_LAST  = 36'd1 << 8,
    ST_RDN   = 36'd1 << 9,
    ST_RDX   = 36'd1 << 10,
    ST_DIF   = 36'd1 << 11,
    ST_CR1   = 36'd1 << 12,
    ST_CR2   = 36'd1 << 13,
    ST_CR3   = 36'd1 << 14,
    ST_ATW   = 36'd1 << 15,
    ST_M1    = 36'd1 << 16,
    ST_M2    = 36'd1 << 17,
    ST_M3    = 36'd1 << 18,
    ST_M4    = 36'd1 << 19,
    ST_M5    = 36'd1 << 20,
    ST_STR   = 36'd1 << 21,
    ST_SC1   = 36'd1 << 22,
    ST_SCW   = 36'd1 << 23,
    ST_PX    = 36'd1 << 24,
    ST_PY    = 36'd1 << 25,
    ST_PYW   = 36'd1 << 26,
    ST_SW2   = 36'd1 << 27,
    ST_MM    = 36'd1 << 28,
    ST_MM2   = 36'd1 << 29,
    ST_MI    = 36'd1 << 30,
    ST_MI2   = 36'd1 << 31,
    ST_MI3   = 36'd1 << 32,
    ST_MI4   = 36'd1 << 33,
    ST_HD    = 36'd1 << 34,
    ST_OUT   = 36'd1 << 35
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [10:0] plen_q;
  logic [15:0] gain_x_q, gain_h_q, speed_q, tstep_q, inv_wb_q;

  // path table
  logic [63:0]   path_mem [MAX_PATH_POINTS];
  logic [63:0]   mem_rdata_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;
  logic [31:0]   rx, ry;

  // control
  logic [AW-1:0] i_q, i_d, cmp_idx_q, cmp_idx_d, nearest_q, nearest_d;
  logic          have_q, have_d, cmp_pend_q, cmp_pend_d;

  // datapath
  logic [64:0]        best_q, best_d;
  logic [63:0]        sx_q, sx_d, acc_q, acc_d, t_q, t_d;
  logic [32:0]        dy_q, dy_d;
  logic [31:0]        pnx_q, pnx_d, pny_q, pny_d;
  logic [31:0]        dpx_q, dpx_d, dpy_q, dpy_d, dvx_q, dvx_d, dvy_q, dvy_d;
  logic [31:0]        cross_q, cross_d, d_q, d_d, cos_q, cos_d, sin_q, sin_d;
  logic [15:0]        herr_q, herr_d, steer_q, steer_d;
  logic [49:0]        p_q, p_d;
  logic [33:0]        m_q, m_d;
  logic [31:0]        vx_q, vx_d, vy_q, vy_d;
  logic [15:0]        hd_q, hd_d;

  // output register
  logic        out_valid_q, out_valid_d, out_load;
  logic [15:0] o_steer_q, o_head_q;
  logic [31:0] o_x_q, o_y_q, o_cross_q;
  logic [9:0]  o_near_q;

  // shared units
  logic signed [MW-1:0]              mul_a, mul_b;
  logic [ptsc_pkg::ProdW-1:0]        prod;
  ptsc_pkg::cordic_req_t             creq;
  ptsc_pkg::cordic_rsp_t             crsp;

  // helper values
  logic [NW-1:0]       plen_w, n_use, i_next, nxt_w;
  logic [AW-1:0]       nxt_addr;
  logic signed [32:0]  scan_dx, scan_dy;
  logic [64:0]         sq_sum;
  logic                better;
  logic signed [65:0]  cr_diff, cr_sh;
  logic signed [67:0]  pos_rnd, pos_sh, m_rnd, m_sh;
  logic signed [65:0]  pos_sum;
  logic [31:0]         pos_base;
  logic [63:0]         st_sum, hd_sum;
  ptsc_pkg::op_e       op;

  ptsc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ptsc_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  assign op = ptsc_pkg::op_e'(req_i.operation);
  assign rx = mem_rdata_q[63:32];
  assign ry = mem_rdata_q[31:0];

  assign plen_w = NW'(plen_q);
  assign n_use  = (plen_w < NW'(2)) ? NW'(2) :
                  (plen_w > NW'(MAX_PATH_POINTS)) ? NW'(MAX_PATH_POINTS) : plen_w;
  assign i_next = NW'(i_q) + NW'(1);
  assign nxt_w  = NW'(nearest_q) + NW'(1);
  assign nxt_addr = (nxt_w >= n_use) ? '0 : nxt_w[AW-1:0];

  assign scan_dx = $signed({rx[31], rx}) - $signed({vx_q[31], vx_q});
  assign scan_dy = $signed({ry[31], ry}) - $signed({vy_q[31], vy_q});
  assign sq_sum  = {1'b0, sx_q} + {1'b0, prod[63:0]};
  assign better  = !have_q || (sq_sum < best_q);

  assign cr_diff = $signed({{2{acc_q[63]}}, acc_q}) - $signed({{2{prod[63]}}, prod[63:0]})
                   + 66'sd32768;
  assign cr_sh   = cr_diff >>> 16;

  assign pos_base = (state_q == ST_PY) ? vx_q : vy_q;
  assign pos_rnd  = $signed(prod) + 68'sh20_0000_0000;
  assign pos_sh   = pos_rnd >>> 38;
  assign pos_sum  = $signed({{34{pos_base[31]}}, pos_base}) + $signed(pos_sh[65:0]);

  assign m_rnd = $signed(prod) + 68'sh2000_0000;
  assign m_sh  = m_rnd >>> 30;

  assign st_sum = t_q + 64'h0000_0080_0000_0000;
  assign hd_sum = t_q + 64'h0000_8000_0000_0000;

  assign req_i.ready = (state_q == ST_IDLE);
  assign mem_we  = req_i.valid && (state_q == ST_IDLE) && (op == ptsc_pkg::OP_LOAD) &&
                   (NW'(req_i.point_index) < NW'(MAX_PATH_POINTS));
  assign wr_addr = AW'(req_i.point_index);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    cmp_idx_d  = cmp_idx_q;
    nearest_d  = nearest_q;
    have_d     = have_q;
    cmp_pend_d = cmp_pend_q;
    best_d     = best_q;
    sx_d       = sx_q;
    acc_d      = acc_q;
    t_d        = t_q;
    dy_d       = dy_q;
    pnx_d      = pnx_q;
    pny_d      = pny_q;
    dpx_d      = dpx_q;
    dpy_d      = dpy_q;
    dvx_d      = dvx_q;
    dvy_d      = dvy_q;
    cross_d    = cross_q;
    d_d        = d_q;
    cos_d      = cos_q;
    sin_d      = sin_q;
    herr_d     = herr_q;
    steer_d    = steer_q;
    p_d        = p_q;
    m_d        = m_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    hd_d       = hd_q;
    out_load   = 1'b0;
    rd_addr    = '0;
    mul_a      = '0;
    mul_b      = '0;
    creq       = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (op)
            ptsc_pkg::OP_START: state_d = ST_S_RD0;
            ptsc_pkg::OP_STEP:  state_d = ST_INIT;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_S_RD0: begin
        rd_addr = '0;
        state_d = ST_S_RD1;
      end
      ST_S_RD1: begin
        rd_addr = AW'(1);
        pnx_d   = rx;
        pny_d   = ry;
        state_d = ST_S_VEC;
      end
      ST_S_VEC: begin
        creq.start = 1'b1;
        creq.mode  = ptsc_pkg::CORDIC_VECTOR;
        creq.vec_y = $signed({ry[31], ry}) - $signed({pny_q[31], pny_q});
        creq.vec_x = $signed({rx[31], rx}) - $signed({pnx_q[31], pnx_q});
        state_d    = ST_S_WT;
      end
      ST_S_WT: begin
        if (crsp.done) begin
          hd_d      = crsp.angle;
          vx_d      = pnx_q;
          vy_d      = pny_q;
          steer_d   = '0;
          nearest_d = '0;
          cross_d   = '0;
          state_d   = ST_OUT;
        end
      end
      ST_INIT: begin
        rd_addr    = '0;
        i_d        = '0;
        have_d     = 1'b0;
        cmp_pend_d = 1'b0;
        state_d    = ST_SCAN0;
      end
      // per point: square of dx, then of dy; the compare trails by one point
      ST_SCAN0: begin
        mul_a = $signed({scan_dx[32], scan_dx});
        mul_b = $signed({scan_dx[32], scan_dx});
        dy_d  = scan_dy;
        if (cmp_pend_q && better) begin
          have_d    = 1'b1;
          best_d    = sq_sum;
          nearest_d = cmp_idx_q;
        end
        state_d = ST_SCAN1;
      end
      ST_SCAN1: begin
        mul_a      = $signed({dy_q[32], dy_q});
        mul_b      = $signed({dy_q[32], dy_q});
        sx_d       = prod[63:0];
        cmp_pend_d = 1'b1;
        cmp_idx_d  = i_q;
        if (i_next < n_use) begin
          rd_addr = i_next[AW-1:0];
          i_d     = i_next[AW-1:0];
          state_d = ST_SCAN0;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (better) begin
          have_d    = 1'b1;
          best_d    = sq_sum;
          nearest_d = cmp_idx_q;
        end
        state_d = ST_RDN;
      end
      ST_RDN: begin
        rd_addr = nearest_q;
        state_d = ST_RDX;
      end
      ST_RDX: begin
        rd_addr = nxt_addr;
        pnx_d   = rx;
        pny_d   = ry;
        state_d = ST_DIF;
      end
      ST_DIF: begin
        dpx_d   = ptsc_pkg::sat32($signed({{34{rx[31]}}, rx}) - $signed({{34{pnx_q[31]}}, pnx_q}));
        dpy_d   = ptsc_pkg::sat32($signed({{34{ry[31]}}, ry}) - $signed({{34{pny_q[31]}}, pny_q}));
        dvx_d   = ptsc_pkg::sat32($signed({{34{vx_q[31]}}, vx_q}) -
                                  $signed({{34{pnx_q[31]}}, pnx_q}));
        dvy_d   = ptsc_pkg::sat32($signed({{34{vy_q[31]}}, vy_q}) -
                                  $signed({{34{pny_q[31]}}, pny_q}));
        state_d = ST_CR1;
      end
      ST_CR1: begin
        mul_a   = $signed({{2{dpy_q[31]}}, dpy_q});
        mul_b   = $signed({{2{dvx_q[31]}}, dvx_q});
        state_d = ST_CR2;
      end
      ST_CR2: begin
        mul_a   = $signed({{2{dpx_q[31]}}, dpx_q});
        mul_b   = $signed({{2{dvy_q[31]}}, dvy_q});
        acc_d   = prod[63:0];
        state_d = ST_CR3;
      end
      ST_CR3: begin
        cross_d    = ptsc_pkg::sat32(cr_sh);
        creq.start = 1'b1;
        creq.mode  = ptsc_pkg::CORDIC_VECTOR;
        creq.vec_y = {dpy_q[31], dpy_q};
        creq.vec_x = {dpx_q[31], dpx_q};
        state_d    = ST_ATW;
      end
      ST_ATW: begin
        if (crsp.done) begin
          herr_d  = crsp.angle - hd_q;
          state_d = ST_M1;
        end
      end
      // steer = round(gx*cross*k + (gh*herr << 32)) at bit 40, gx*cross times k in two halves
      ST_M1: begin
        mul_a   = $signed({{18{gain_x_q[15]}}, gain_x_q});
        mul_b   = $signed({{2{cross_q[31]}}, cross_q});
        state_d = ST_M2;
      end
      ST_M2: begin
        p_d     = prod[49:0];
        mul_a   = $signed({{18{gain_h_q[15]}}, gain_h_q});
        mul_b   = $signed({{18{herr_q[15]}}, herr_q});
        state_d = ST_M3;
      end
      ST_M3: begin
        t_d     = {prod[31:0], 32'd0};
        mul_a   = $signed({10'd0, p_q[23:0]});
        mul_b   = $signed(ptsc_pkg::RadToBam);
        state_d = ST_M4;
      end
      ST_M4: begin
        t_d     = t_q + prod[63:0];
        mul_a   = $signed({{10{p_q[47]}}, p_q[47:24]});
        mul_b   = $signed(ptsc_pkg::RadToBam);
        state_d = ST_M5;
      end
      ST_M5: begin
        t_d     = t_q + {prod[39:0], 24'd0};
        state_d = ST_STR;
      end
      ST_STR: begin
        steer_d = st_sum[55:40];
        mul_a   = $signed({18'd0, speed_q});
        mul_b   = $signed({18'd0, tstep_q});
        state_d = ST_SC1;
      end
      ST_SC1: begin
        d_d        = prod[31:0];
        creq.start = 1'b1;
        creq.mode  = ptsc_pkg::CORDIC_ROTATE;
        creq.angle = hd_q + steer_q;
        state_d    = ST_SCW;
      end
      ST_SCW: begin
        if (crsp.done) begin
          cos_d   = crsp.cos_v;
          sin_d   = crsp.sin_v;
          state_d = ST_PX;
        end
      end
      ST_PX: begin
        mul_a   = $signed({2'd0, d_q});
        mul_b   = $signed({{2{cos_q[31]}}, cos_q});
        state_d = ST_PY;
      end
      ST_PY: begin
        vx_d    = ptsc_pkg::sat32(pos_sum);
        mul_a   = $signed({2'd0, d_q});
        mul_b   = $signed({{2{sin_q[31]}}, sin_q});
        state_d = ST_PYW;
      end
      ST_PYW: begin
        vy_d       = ptsc_pkg::sat32(pos_sum);
        creq.start = 1'b1;
        creq.mode  = ptsc_pkg::CORDIC_ROTATE;
        creq.angle = steer_q;
        state_d    = ST_SW2;
      end
      ST_SW2: begin
        if (crsp.done) begin
          sin_d   = crsp.sin_v;
          state_d = ST_MM;
        end
      end
      ST_MM: begin
        mul_a   = $signed({2'd0, d_q});
        mul_b   = $signed({{2{sin_q[31]}}, sin_q});
        state_d = ST_MM2;
      end
      ST_MM2: begin
        m_d     = m_sh[33:0];
        state_d = ST_MI;
      end
      ST_MI: begin
        mul_a   = $signed(m_q);
        mul_b   = $signed({18'd0, inv_wb_q});
        state_d = ST_MI2;
      end
      ST_MI2: begin
        p_d     = prod[49:0];
        mul_a   = $signed({10'd0, prod[23:0]});
        mul_b   = $signed(ptsc_pkg::RadToBam);
        state_d = ST_MI3;
      end
      ST_MI3: begin
        t_d     = prod[63:0];
        mul_a   = $signed({{8{p_q[49]}}, p_q[49:24]});
        mul_b   = $signed(ptsc_pkg::RadToBam);
        state_d = ST_MI4;
      end
      ST_MI4: begin
        t_d     = t_q + {prod[39:0], 24'd0};
        state_d = ST_HD;
      end
      ST_HD: begin
        hd_d    = hd_q + hd_sum[63:48];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      path_mem[wr_addr] <= {req_i.point_x, req_i.point_y};
    end
    mem_rdata_q <= path_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= ptsc_pkg::PathLengthRst;
      gain_x_q <= ptsc_pkg::GainCrossRst;
      gain_h_q <= ptsc_pkg::GainHeadRst;
      speed_q  <= ptsc_pkg::SpeedRst;
      tstep_q  <= ptsc_pkg::TimeStepRst;
      inv_wb_q <= ptsc_pkg::InvWheelRst;
    end else if (cfg_we_i) begin
      case (ptsc_pkg::cfg_idx_e'(cfg_idx_i))
        ptsc_pkg::CFG_PATH_LENGTH: plen_q   <= cfg_data_i[10:0];
        ptsc_pkg::CFG_GAIN_CROSS:  gain_x_q <= cfg_data_i;
        ptsc_pkg::CFG_GAIN_HEAD:   gain_h_q <= cfg_data_i;
        ptsc_pkg::CFG_SPEED:       speed_q  <= cfg_data_i;
        ptsc_pkg::CFG_TIME_STEP:   tstep_q  <= cfg_data_i;
        ptsc_pkg::CFG_INV_WHEEL:   inv_wb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      cmp_idx_q   <= '0;
      nearest_q   <= '0;
      have_q      <= 1'b0;
      cmp_pend_q  <= 1'b0;
      vx_q        <= '0;
      vy_q        <= '0;
      hd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      cmp_idx_q   <= cmp_idx_d;
      nearest_q   <= nearest_d;
      have_q      <= have_d;
      cmp_pend_q  <= cmp_pend_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      hd_q        <= hd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    sx_q    <= sx_d;
    acc_q   <= acc_d;
    t_q     <= t_d;
    dy_q    <= dy_d;
    pnx_q   <= pnx_d;
    pny_q   <= pny_d;
    dpx_q   <= dpx_d;
    dpy_q   <= dpy_d;
    dvx_q   <= dvx_d;
    dvy_q   <= dvy_d;
    cross_q <= cross_d;
    d_q     <= d_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
    herr_q  <= herr_d;
    steer_q <= steer_d;
    p_q     <= p_d;
    m_q     <= m_d;
    if (out_load) begin
      o_steer_q <= steer_q;
      o_x_q     <= vx_q;
      o_y_q     <= vy_q;
      o_head_q  <= hd_q;
      o_near_q  <= 10'(nearest_q);
      o_cross_q <= cross_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.steer_angle   = o_steer_q;
  assign rsp_o.pose_x        = o_x_q;
  assign rsp_o.pose_y        = o_y_q;
  assign rsp_o.pose_heading  = o_head_q;
  assign rsp_o.nearest_index = o_near_q;
  assign rsp_o.cross_track   = o_cross_q;

endmodule

// ----- dv/tb_path_tracking_steer_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_tracking_steer_controller
// Drives load, start, step and no-op words into the steering controller with random
// gaps and output stalls. A scoreboard keeps its own path table, pose and
// register copies, predicts every result word and checks it field by field.
// ----------------------------------------------------------------------------
module tb_path_tracking_steer_controller;

  localparam int unsigned PathDepth   = 1024;
  localparam int unsigned DrainCycles = 2400;
  localparam longint      BamPerRad   = 64'sd683565276;
  localparam longint      CordicK     = 64'sd652032874;
  localparam logic [31:0] AtanLut [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic [15:0] steer;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [9:0]  near_idx;
    logic [31:0] xtrack;
  } pose_word_t;

  class steer_scoreboard;
    logic [31:0] path_x [PathDepth];
    logic [31:0] path_y [PathDepth];
    logic [31:0] veh_x, veh_y;
    logic [15:0] veh_h;
    logic [10:0] path_len;
    longint      gain_xt, gain_hd, spd, dt, inv_wb;
    pose_word_t  pending [$];
    int          fails;

    function new();
      veh_x = '0; veh_y = '0; veh_h = '0;
      path_len = 11'd2; gain_xt = 256; gain_hd = 256;
      spd = 768; dt = 1638; inv_wb = 64; fails = 0;
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, field, got, want);
      fails++;
    endtask

    function void set_reg(ptsc_pkg::cfg_idx_e r, logic [15:0] v);
      case (r)
        ptsc_pkg::CFG_PATH_LENGTH: path_len = v[10:0];
        ptsc_pkg::CFG_GAIN_CROSS:  gain_xt = longint'($signed(v));
        ptsc_pkg::CFG_GAIN_HEAD:   gain_hd = longint'($signed(v));
        ptsc_pkg::CFG_SPEED:       spd = longint'(v);
        ptsc_pkg::CFG_TIME_STEP:   dt = longint'(v);
        ptsc_pkg::CFG_INV_WHEEL:   inv_wb = longint'(v);
        default: ;
      endcase
    endfunction

    function logic [31:0] clip32(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'h7fff_ffff;
      if (v < -66'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function logic [15:0] vec_angle(longint vy, longint vx);
      logic [31:0] z;
      longint xs, ys;
      z = '0;
      if (vx == 0 && vy == 0) return 16'd0;
      if (vx < 0) begin
        vx = -vx; vy = -vy; z = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy > 0) begin
          vx += ys; vy -= xs; z += AtanLut[i];
        end else begin
          vx -= ys; vy += xs; z -= AtanLut[i];
        end
      end
      z = z + 32'h8000;
      return z[31:16];
    endfunction

    function void rotate(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] z32;
      logic        flip;
      longint      x, y, z, xs, ys;
      z32 = {ang, 16'h0};
      flip = 1'b0;
      if (((z32 + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        z32 += 32'h8000_0000; flip = 1'b1;
      end
      z = longint'($signed(z32));
      x = CordicK; y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(AtanLut[i]);
        end else begin
          x += ys; y -= xs; z += longint'(AtanLut[i]);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = x;
      s = y;
    endfunction

    function pose_word_t control_step();
      pose_word_t w;
      int unsigned n, best, nxt;
      logic [32:0] ax, ay;
      logic [65:0] d2, best_d2;
      longint dx, dy, dpx, dpy, dvx, dvy, herr, d, c, s, m;
      logic signed [65:0] cp;
      logic [15:0] hpath, hdiff, steer;
      logic [63:0] acc;
      n = path_len < 2 ? 2 : (path_len > PathDepth ? PathDepth : path_len);
      best = 0;
      best_d2 = '1;
      for (int unsigned i = 0; i < n; i++) begin
        dx = longint'($signed(path_x[i])) - longint'($signed(veh_x));
        dy = longint'($signed(path_y[i])) - longint'($signed(veh_y));
        ax = dx < 0 ? 33'(-dx) : 33'(dx);
        ay = dy < 0 ? 33'(-dy) : 33'(dy);
        d2 = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        if (i == 0 || d2 < best_d2) begin
          best_d2 = d2; best = i;
        end
      end
      nxt = best + 1 >= n ? 0 : best + 1;
      dpx = longint'($signed(clip32(longint'($signed(path_x[nxt]))
                                  - longint'($signed(path_x[best])))));
      dpy = longint'($signed(clip32(longint'($signed(path_y[nxt]))
                                  - longint'($signed(path_y[best])))));
      dvx = longint'($signed(clip32(longint'($signed(veh_x))
                                  - longint'($signed(path_x[best])))));
      dvy = longint'($signed(clip32(longint'($signed(veh_y))
                                  - longint'($signed(path_y[best])))));
      cp = 66'(dpy) * 66'(dvx) - 66'(dpx) * 66'(dvy) + 66'sd32768;
      w.xtrack = clip32(cp >>> 16);
      hpath = vec_angle(dpy, dpx);
      hdiff = hpath - veh_h;
      herr = longint'($signed(hdiff));
      acc = 64'(gain_xt * longint'($signed(w.xtrack)) * BamPerRad)
          + 64'((gain_hd * herr) << 32);
      acc = acc + (64'd1 << 39);
      steer = acc[55:40];
      // pose moves along heading plus steer
      d = spd * dt;
      rotate(veh_h + steer, c, s);
      veh_x = clip32(longint'($signed(veh_x)) + ((d * c + (64'sd1 <<< 37)) >>> 38));
      veh_y = clip32(longint'($signed(veh_y)) + ((d * s + (64'sd1 <<< 37)) >>> 38));
      rotate(steer, c, s);
      m = (d * s + (64'sd1 <<< 29)) >>> 30;
      acc = 64'(m * inv_wb * BamPerRad) + (64'd1 << 47);
      veh_h = veh_h + acc[63:48];
      w.steer = steer;
      w.pos_x = veh_x;
      w.pos_y = veh_y;
      w.heading = veh_h;
      w.near_idx = best[9:0];
      return w;
    endfunction

    function void note(ptsc_pkg::op_e op, logic [9:0] idx, logic [31:0] x,
                       logic [31:0] y);
      pose_word_t w;
      case (op)
        ptsc_pkg::OP_LOAD: begin
          path_x[idx] = x;
          path_y[idx] = y;
        end
        ptsc_pkg::OP_START: begin
          veh_x = path_x[0];
          veh_y = path_y[0];
          veh_h = vec_angle(longint'($signed(path_y[1])) - longint'($signed(path_y[0])),
                            longint'($signed(path_x[1])) - longint'($signed(path_x[0])));
          w = '{steer: '0, pos_x: veh_x, pos_y: veh_y, heading: veh_h,
                near_idx: '0, xtrack: '0};
          pending.push_back(w);
        end
        ptsc_pkg::OP_STEP: pending.push_back(control_step());
        default: ;
      endcase
    endfunction

    task check(pose_word_t got);
      pose_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.steer, '0);
        return;
      end
      want = pending.pop_front();
      if (got.steer !== want.steer) report("steer_angle", got.steer, want.steer);
      if (got.pos_x !== want.pos_x) report("pose_x", got.pos_x, want.pos_x);
      if (got.pos_y !== want.pos_y) report("pose_y", got.pos_y, want.pos_y);
      if (got.heading !== want.heading) report("pose_heading", got.heading, want.heading);
      if (got.near_idx !== want.near_idx)
        report("nearest_index", got.near_idx, want.near_idx);
      if (got.xtrack !== want.xtrack) report("cross_track", got.xtrack, want.xtrack);
    endtask
  endclass

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  logic [ptsc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ptsc_pkg::CfgDataW-1:0] cfg_data;

  ptsc_in_if  req_if ();
  ptsc_out_if rsp_if ();

  steer_scoreboard sb = new();
  bit  written [PathDepth];
  int  hold_left = 0;
  bit  no_idle = 1'b0;
  int  items_sent = 0;

  path_tracking_steer_controller DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int written_prefix();
    for (int i = 0; i < PathDepth; i++) begin
      if (!written[i]) return i;
    end
    return PathDepth;
  endfunction

  task automatic send_word(ptsc_pkg::op_e op, logic [9:0] idx, logic [31:0] x,
                           logic [31:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.point_index <= idx;
    req_if.point_x     <= x;
    req_if.point_y     <= y;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note(op, idx, x, y);
    if (op == ptsc_pkg::OP_LOAD) written[idx] = 1'b1;
    items_sent++;
  endtask

  // wait until the block is idle: no words owed and the slowest step drained
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(ptsc_pkg::cfg_idx_e r, logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(r, v);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  task automatic write_all_regs(int upper);
    logic [15:0] len;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) len = 16'd0;
    else if (r == 1) len = 16'd1;
    else if (r == 2 && upper == PathDepth) len = 16'd2047;
    else len = 16'($urandom_range(2, upper));
    write_reg(ptsc_pkg::CFG_PATH_LENGTH, len);
    write_reg(ptsc_pkg::CFG_GAIN_CROSS, pick_gain());
    write_reg(ptsc_pkg::CFG_GAIN_HEAD, pick_gain());
    r = $urandom_range(0, 9);
    write_reg(ptsc_pkg::CFG_SPEED, r == 0 ? 16'd0 : r == 1 ? 16'hffff
                                          : 16'($urandom_range(256, 2048)));
    r = $urandom_range(0, 9);
    write_reg(ptsc_pkg::CFG_TIME_STEP, r == 0 ? 16'd0 : r == 1 ? 16'hffff
                                          : 16'($urandom_range(500, 5000)));
    r = $urandom_range(0, 9);
    write_reg(ptsc_pkg::CFG_INV_WHEEL, r == 0 ? 16'd0 : r == 1 ? 16'hffff
                                          : 16'($urandom_range(16, 512)));
  endtask

  task automatic load_path(int len);
    int cx, cy;
    bit wild;
    wild = ($urandom_range(0, 4) == 0);
    cx = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    cy = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    for (int i = 0; i < len; i++) begin
      if (wild) begin
        cx = $urandom;
        cy = $urandom;
      end else begin
        cx += int'($urandom_range(0, 262144)) - 65536;
        cy += int'($urandom_range(0, 131072)) - 65536;
      end
      send_word(ptsc_pkg::OP_LOAD, 10'(i), cx, cy);
    end
  endtask

  task automatic drive_steps(int steps);
    send_word(ptsc_pkg::OP_START, 10'($urandom), $urandom, $urandom);
    for (int k = 0; k < steps; k++) begin
      case ($urandom_range(0, 19))
        0: send_word(ptsc_pkg::OP_NONE, 10'($urandom), $urandom, $urandom);
        1: send_word(ptsc_pkg::OP_LOAD, 10'($urandom), $urandom, $urandom);
        2: send_word(ptsc_pkg::OP_START, 10'($urandom), $urandom, $urandom);
        default: ;
      endcase
      send_word(ptsc_pkg::OP_STEP, 10'($urandom), $urandom, $urandom);
    end
  endtask

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int stall_left;
    pose_word_t got;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got = '{steer: rsp_if.steer_angle, pos_x: rsp_if.pose_x, pos_y: rsp_if.pose_y,
                heading: rsp_if.pose_heading, near_idx: rsp_if.nearest_index,
                xtrack: rsp_if.cross_track};
        sb.check(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle) begin
          case ($urandom_range(0, 19))
            0, 1: stall_left = $urandom_range(1, 3);
            2:    stall_left = $urandom_range(15, 60);
            default: ;
          endcase
        end
      end
    end
  end

  initial begin
    int phase;
    int len;
    req_if.valid       <= 1'b0;
    req_if.operation   <= ptsc_pkg::OP_NONE;
    req_if.point_index <= '0;
    req_if.point_x     <= '0;
    req_if.point_y     <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= ptsc_pkg::CFG_PATH_LENGTH;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // zero segment and tie on identical points
    send_word(ptsc_pkg::OP_LOAD, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_LOAD, 10'd1, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_START, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    // segment pointing backward, then saturating differences
    send_word(ptsc_pkg::OP_LOAD, 10'd1, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ptsc_pkg::OP_START, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_LOAD, 10'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_word(ptsc_pkg::OP_START, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_NONE, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ptsc_pkg::OP_LOAD, 10'h3ff, 32'hffff_ffff, 32'h0000_0000);
    send_word(ptsc_pkg::OP_LOAD, 10'd2, 32'h0001_0000, 32'hffff_0000);
    settle();

    write_reg(ptsc_pkg::CFG_PATH_LENGTH, 16'd1);
    write_reg(ptsc_pkg::CFG_GAIN_CROSS, 16'h7fff);
    write_reg(ptsc_pkg::CFG_GAIN_HEAD, 16'h8000);
    write_reg(ptsc_pkg::CFG_SPEED, 16'hffff);
    write_reg(ptsc_pkg::CFG_TIME_STEP, 16'hffff);
    write_reg(ptsc_pkg::CFG_INV_WHEEL, 16'hffff);
    send_word(ptsc_pkg::OP_START, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    settle();

    write_reg(ptsc_pkg::CFG_PATH_LENGTH, 16'd0);
    write_reg(ptsc_pkg::CFG_GAIN_CROSS, 16'h8000);
    write_reg(ptsc_pkg::CFG_GAIN_HEAD, 16'h7fff);
    write_reg(ptsc_pkg::CFG_SPEED, 16'd0);
    write_reg(ptsc_pkg::CFG_TIME_STEP, 16'd0);
    write_reg(ptsc_pkg::CFG_INV_WHEEL, 16'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    send_word(ptsc_pkg::OP_STEP, 10'd0, 32'd0, 32'd0);
    settle();

    phase = 0;
    while (items_sent < 540) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
      no_idle = ($urandom_range(0, 3) == 0);
      write_all_regs(written_prefix() > len ? written_prefix() : len);
      load_path(len);
      if (phase == 3) begin
        // output held off long enough that the block stalls its input
        no_idle = 1'b0;
        hold_left = 3000;
      end
      drive_steps($urandom_range(4, 12));
      settle();
      phase++;
    end

    if (sb.pending.size() != 0) sb.report("words never seen", sb.pending.size(), '0);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
